### hdl/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Types, constants and the lead byte decode shared by the UTF-8 decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

   localparam int BYTE_W   = 8;
   localparam int CODE_W   = 21;
   localparam int STATUS_W = 2;
   localparam int LEFT_W   = 2;

   localparam logic [CODE_W-1:0] REPLACEMENT_CODE = 21'h00FFFD;

   typedef enum logic [STATUS_W-1:0] {
      ST_COMPLETE     = 2'd0,
      ST_INVALID_LEAD = 2'd1,
      ST_BAD_CONT     = 2'd2,
      ST_CUT_BY_ZERO  = 2'd3
   } status_type;

   typedef struct packed {
      logic [CODE_W-1:0] code_point;
      status_type        status;
      logic              last_of_run;
   } result_type;

   // Outcome of decoding one byte as a lead byte while idle.
   typedef struct packed {
      logic              emit;
      logic [CODE_W-1:0] code_point;
      status_type        status;
      logic [LEFT_W-1:0] bytes_left;
      logic [CODE_W-1:0] partial_code;
   } lead_type;

   function automatic lead_type lead_decode(input logic [BYTE_W-1:0] b);
      lead_type r;
      r = '{emit: 1'b0, code_point: '0, status: ST_COMPLETE,
            bytes_left: '0, partial_code: '0};
      if (b < 8'h80) begin
         r.emit       = 1'b1;
         r.code_point = {{(CODE_W-BYTE_W){1'b0}}, b};
      end else if (b < 8'hC2 || b >= 8'hF5) begin
         r.emit   = 1'b1;
         r.status = ST_INVALID_LEAD;
      end else if (b < 8'hE0) begin
         r.bytes_left   = 2'd1;
         r.partial_code = {{(CODE_W-5){1'b0}}, b[4:0]};
      end else if (b < 8'hF0) begin
         r.bytes_left   = 2'd2;
         r.partial_code = {{(CODE_W-4){1'b0}}, b[3:0]};
      end else begin
         r.bytes_left   = 2'd3;
         r.partial_code = {{(CODE_W-3){1'b0}}, b[2:0]};
      end
      return r;
   endfunction

endpackage

### hdl/utf8d_if.sv
// ----------------------------------------------------------------------------
// utf8d_req_if / utf8d_rsp_if
// Valid/ready channels for raw bytes in and decoded results out.
// ----------------------------------------------------------------------------
interface utf8d_req_if;
   logic                          valid;
   logic                          ready;
   logic [utf8d_pkg::BYTE_W-1:0]  in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface utf8d_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [utf8d_pkg::CODE_W-1:0]  code_point;
   utf8d_pkg::status_type         status;
   logic                          last_of_run;

   modport source (output valid, output code_point, output status, output last_of_run,
                   input ready);
   modport sink   (input valid, input code_point, input status, input last_of_run,
                   output ready);
endinterface

### hdl/utf8_stream_decoder_top.sv
// A byte accepted on req passes the input register, then the result queue, before its first
// result can be accepted on rsp.
// Throughput: one byte per cycle while rsp accepts results; a byte that gives two results
// holds the input until the queue has drained, since it drains one transaction per cycle.
// Reset (synchronous, active high) empties the input register and result queue and
// returns the decoder to idle between characters.
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// Streaming UTF-8 decoder: input byte register, single-pass decode, and a
// two-entry result queue feeding the rsp channel.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top (
   input  logic               clock,
   input  logic               reset,
   utf8d_req_if.sink          req,
   utf8d_rsp_if.source        rsp
);

   // input register
   logic                              in_vld_ff, in_vld_in;
   logic [utf8d_pkg::BYTE_W-1:0]      in_byte_ff, in_byte_in;

   // decoder state
   logic [utf8d_pkg::LEFT_W-1:0]      left_ff, left_in;
   logic [utf8d_pkg::CODE_W-1:0]      partial_ff, partial_in;

   // result queue, entry 0 is the head
   utf8d_pkg::result_type             q0_ff, q0_in, q1_ff, q1_in;
   logic [1:0]                        cnt_ff, cnt_in;

   utf8d_pkg::result_type             r0, r1;
   logic [1:0]                        n_res;
   utf8d_pkg::lead_type               lead;
   logic [utf8d_pkg::LEFT_W-1:0]      left_dec;
   logic [utf8d_pkg::CODE_W-1:0]      partial_dec, shifted;
   logic                              pop, consume, accept;
   logic [1:0]                        cnt_after, n_push;
   utf8d_pkg::result_type             base0;

   // --- decode of the registered byte ---
   always_comb begin
      lead        = utf8d_pkg::lead_decode(in_byte_ff);
      shifted     = {partial_ff[utf8d_pkg::CODE_W-7:0], in_byte_ff[5:0]};
      r0          = '{code_point: '0, status: utf8d_pkg::ST_COMPLETE, last_of_run: 1'b1};
      r1          = '{code_point: lead.code_point, status: lead.status, last_of_run: 1'b1};
      n_res       = 2'd0;
      left_dec    = '0;
      partial_dec = '0;
      if (left_ff == '0) begin
         r0.code_point = lead.code_point;
         r0.status     = lead.status;
         n_res         = {1'b0, lead.emit};
         left_dec      = lead.bytes_left;
         partial_dec   = lead.partial_code;
      end else if (in_byte_ff == '0) begin
         r0.code_point = partial_ff;
         r0.status     = utf8d_pkg::ST_CUT_BY_ZERO;
         n_res         = 2'd1;
      end else if (in_byte_ff[7:6] == 2'b10) begin
         left_dec = left_ff - 2'd1;
         if (left_ff == 2'd1) begin
            r0.code_point = shifted;
            n_res         = 2'd1;
         end else begin
            partial_dec = shifted;
         end
      end else begin
         // not a continuation: replace, then decode the byte again as a lead
         r0.code_point  = utf8d_pkg::REPLACEMENT_CODE;
         r0.status      = utf8d_pkg::ST_BAD_CONT;
         r0.last_of_run = ~lead.emit;
         n_res          = lead.emit ? 2'd2 : 2'd1;
         left_dec       = lead.bytes_left;
         partial_dec    = lead.partial_code;
      end
   end

   // --- handshake and queue control ---
   assign pop       = rsp.valid & rsp.ready;
   assign cnt_after = cnt_ff - {1'b0, pop};
   assign consume   = in_vld_ff & ((2'd2 - cnt_after) >= n_res);
   assign req.ready = ~in_vld_ff | consume;
   assign accept    = req.valid & req.ready;
   assign n_push    = consume ? n_res : 2'd0;

   assign rsp.valid       = (cnt_ff != 2'd0);
   assign rsp.code_point  = q0_ff.code_point;
   assign rsp.status      = q0_ff.status;
   assign rsp.last_of_run = q0_ff.last_of_run;

   always_comb begin
      in_vld_in  = accept | (in_vld_ff & ~consume);
      in_byte_in = accept ? req.in_byte : in_byte_ff;
      left_in    = consume ? left_dec : left_ff;
      partial_in = consume ? partial_dec : partial_ff;

      base0  = pop ? q1_ff : q0_ff;
      cnt_in = cnt_after + n_push;
      q0_in  = (cnt_after == 2'd0 && n_push != 2'd0) ? r0 : base0;
      if (cnt_after == 2'd0) begin
         q1_in = r1;
      end else if (n_push != 2'd0) begin
         q1_in = r0;
      end else begin
         q1_in = q1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         left_ff    <= '0;
         partial_ff <= '0;
         cnt_ff     <= 2'd0;
      end else begin
         in_vld_ff  <= in_vld_in;
         left_ff    <= left_in;
         partial_ff <= partial_in;
         cnt_ff     <= cnt_in;
      end
      in_byte_ff <= in_byte_in;
      q0_ff      <= q0_in;
      q1_ff      <= q1_in;
   end

endmodule

### hdl/utf8d_checker.sv
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level assertions for the UTF-8 decoder, bound to the top level.
// ----------------------------------------------------------------------------
module utf8d_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [utf8d_pkg::CODE_W-1:0]   rsp_code_point,
   input utf8d_pkg::status_type          rsp_status,
   input logic                           rsp_last_of_run
);

   // a stalled result transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_point)
         && $stable(rsp_status) && $stable(rsp_last_of_run))
      else $error("rsp payload changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   a_invalid_lead: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == utf8d_pkg::ST_INVALID_LEAD
         |-> rsp_code_point == '0 && rsp_last_of_run)
      else $error("invalid lead result malformed");

   a_replacement: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == utf8d_pkg::ST_BAD_CONT
         |-> rsp_code_point == utf8d_pkg::REPLACEMENT_CODE)
      else $error("replacement result carries wrong code");

   // a result that is not last is the replacement, followed by its lead result
   a_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> rsp_status == utf8d_pkg::ST_BAD_CONT)
      else $error("non-final result with unexpected status");

endmodule

bind utf8_stream_decoder_top utf8d_checker u_utf8d_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_code_point  (rsp.code_point),
   .rsp_status      (rsp.status),
   .rsp_last_of_run (rsp.last_of_run)
);
